/* hdl/cartesian_to_spherical_assert.svh */
// ----------------------------------------------------------------------------
// Cartesian to spherical assertion macros
// Clocked property wrappers shared by the checker; reset disables each check.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH

// same-cycle implication
`define C2S_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C2S_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/c2s_pkg.sv */
// ----------------------------------------------------------------------------
// Cartesian to spherical package
// Internal widths and elaboration-time arctangent table functions.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

	localparam int INT_W    = 64;
	localparam int INT_FRAC = 60;
	localparam int NORM_TOP = 57;
	localparam int OPER_W   = 58;
	localparam int G_W      = 6;

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int j = 63; j >= 0; j--) begin
			r = {r[63:0], n[j]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] series_sum(input logic [63:0] p0, input logic [63:0] dv,
		input int sh);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] k;
		logic [63:0] t;
		p   = p0;
		sum = '0;
		k   = '0;
		for (int n = 0; n < 64; n++) begin
			if (p != '0) begin
				t = udiv64(p, (k << 1) + 64'd1);
				if (k[0]) begin
					sum = sum - t;
				end else begin
					sum = sum + t;
				end
				k = k + 64'd1;
				if (sh >= 64) begin
					p = '0;
				end else begin
					p = udiv64(p >> sh, dv);
				end
			end
		end
		return sum;
	endfunction

	// atan(2^-i) in Q4.60; entry 0 is atan(1/2) + atan(1/3)
	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0] v;
		if (i == 0) begin
			v = series_sum(64'd1 << 59, 64'd4, 0)
				+ series_sum(udiv64(64'd1 << 60, 64'd3), 64'd9, 0);
		end else begin
			v = series_sum(64'd1 << (INT_FRAC - i), 64'd1, 2 * i);
		end
		return v;
	endfunction

	function automatic logic [63:0] pi_round(input int afb);
		logic [63:0] pv;
		int sh;
		sh = INT_FRAC - afb;
		pv = atan_entry(0) << 2;
		return (pv + (64'd1 << (sh - 1))) >> sh;
	endfunction

endpackage

`default_nettype wire

/* hdl/cartesian_to_spherical.sv */
// ----------------------------------------------------------------------------
// Cartesian to spherical converter.
// One transaction per cycle; the 58-stage square-root pipeline for the xy radius and one
// CORDIC stage per micro-rotation set the latency. All stages hold while a result stalls.
// Reset clears the valid bits only; no other state is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical #(
	parameter int COORD_WIDTH     = 32,
	parameter int ANGLE_FRAC_BITS = 29,
	parameter int ROTATION_STEPS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pt_valid,
	output logic                              pt_stall,
	input  logic signed [COORD_WIDTH-1:0]     coord_x,
	input  logic signed [COORD_WIDTH-1:0]     coord_y,
	input  logic signed [COORD_WIDTH-1:0]     coord_z,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [COORD_WIDTH-1:0]            radius,
	output logic [ANGLE_FRAC_BITS+1:0]        polar_angle,
	output logic signed [ANGLE_FRAC_BITS+2:0] azimuth_angle
);
	import c2s_pkg::*;

	localparam int CW         = COORD_WIDTH;
	localparam int SQ_W       = 2 * CW;
	localparam int SXY_W      = SQ_W + 1;
	localparam int SALL_W     = SQ_W + 2;
	localparam int RAD_ROOT_W = CW + 1;
	localparam int RHO_RAD_W  = 2 * OPER_W;
	localparam int RAD_DLY    = OPER_W - RAD_ROOT_W;
	localparam int BW         = $clog2(CW + 1);
	localparam int AW         = ANGLE_FRAC_BITS + 3;
	localparam int SIDE_RHO   = 3 * INT_W + 1;
	localparam logic [63:0] PI_RND = pi_round(ANGLE_FRAC_BITS);
	localparam logic signed [AW-1:0] PI_F = $signed(PI_RND[AW-1:0]);

	logic adv;
	logic res_valid_q;

	assign adv      = !(res_valid_q && res_stall);
	assign pt_stall = !adv;

	// stage 1: magnitudes
	logic signed [CW-1:0] coord [3];
	logic [CW-1:0] mag_s1 [3];
	logic          neg_s1 [3];
	logic          vld_s1;

	assign coord[0] = coord_x;
	assign coord[1] = coord_y;
	assign coord[2] = coord_z;

	// stage 2: squares and largest magnitude
	logic [SQ_W-1:0] sq_s2  [3];
	logic [CW-1:0]   mag_s2 [3];
	logic            neg_s2 [3];
	logic [CW-1:0]   m_s2;
	logic            xy_nz_s2;
	logic            vld_s2;
	logic [CW-1:0]   m_c;

	// stage 3: xy sum and bit length
	logic [SXY_W-1:0] sxy_s3;
	logic [SQ_W-1:0]  sqz_s3;
	logic [BW-1:0]    b_s3;
	logic [CW-1:0]    mag_s3 [3];
	logic             neg_s3 [3];
	logic             m_nz_s3;
	logic             xy_nz_s3;
	logic             vld_s3;
	logic [BW-1:0]    b_c;

	// stage 4: full sum and shift amount
	logic [SALL_W-1:0] sall_s4;
	logic [SXY_W-1:0]  sxy_s4;
	logic [G_W-1:0]    g_s4;
	logic [CW-1:0]     mag_s4 [3];
	logic              neg_s4 [3];
	logic              m_nz_s4;
	logic              xy_nz_s4;
	logic              vld_s4;

	// stage 5: normalized operands
	logic [SALL_W-1:0]       sall_s5;
	logic [RHO_RAD_W-1:0]    rrad_s5;
	logic signed [INT_W-1:0] sc_s5 [3];
	logic                    m_nz_s5;
	logic                    xy_nz_s5;
	logic                    vld_s5;

	always_comb begin
		m_c = mag_s1[0];
		if (mag_s1[1] > m_c) begin
			m_c = mag_s1[1];
		end
		if (mag_s1[2] > m_c) begin
			m_c = mag_s1[2];
		end
	end

	always_comb begin
		b_c = '0;
		for (int i = 0; i < CW; i++) begin
			if (m_s2[i]) begin
				b_c = BW'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pt_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= coord[k][CW-1];
				mag_s1[k] <= coord[k][CW-1] ? CW'(-coord[k]) : CW'(coord[k]);
				sq_s2[k]  <= SQ_W'(mag_s1[k]) * SQ_W'(mag_s1[k]);
				mag_s2[k] <= mag_s1[k];
				neg_s2[k] <= neg_s1[k];
				mag_s3[k] <= mag_s2[k];
				neg_s3[k] <= neg_s2[k];
				mag_s4[k] <= mag_s3[k];
				neg_s4[k] <= neg_s3[k];
				sc_s5[k]  <= neg_s4[k] ? -$signed(INT_W'(mag_s4[k]) << g_s4)
					: $signed(INT_W'(mag_s4[k]) << g_s4);
			end
			m_s2     <= m_c;
			xy_nz_s2 <= (|mag_s1[0]) || (|mag_s1[1]);
			sxy_s3   <= SXY_W'(sq_s2[0]) + SXY_W'(sq_s2[1]);
			sqz_s3   <= sq_s2[2];
			b_s3     <= b_c;
			m_nz_s3  <= |m_s2;
			xy_nz_s3 <= xy_nz_s2;
			sall_s4  <= SALL_W'(sxy_s3) + SALL_W'(sqz_s3);
			sxy_s4   <= sxy_s3;
			g_s4     <= G_W'(NORM_TOP) - G_W'(b_s3);
			m_nz_s4  <= m_nz_s3;
			xy_nz_s4 <= xy_nz_s3;
			sall_s5  <= sall_s4;
			rrad_s5  <= RHO_RAD_W'(sxy_s4) << {g_s4, 1'b0};
			m_nz_s5  <= m_nz_s4;
			xy_nz_s5 <= xy_nz_s4;
		end
	end

	// radius root, then aligned with the xy root
	logic                  rr_vld;
	logic [RAD_ROOT_W-1:0] rr_root;
	logic                  rr_mnz;
	logic [CW-1:0]         rr_sat;

	c2s_sqrt #(
		.ROOT_W (RAD_ROOT_W),
		.SIDE_W (1)
	) u_rad_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s5),
		.rad_in   (sall_s5),
		.side_in  (m_nz_s5),
		.vld_out  (rr_vld),
		.root_out (rr_root),
		.side_out (rr_mnz)
	);

	assign rr_sat = rr_root[CW] ? '1 : rr_root[CW-1:0];

	logic [CW-1:0] dly_rad_q [RAD_DLY];
	logic          dly_mnz_q [RAD_DLY];
	logic          dly_vld_q [RAD_DLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RAD_DLY; i++) begin
				dly_vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			dly_vld_q[0] <= rr_vld;
			for (int i = 1; i < RAD_DLY; i++) begin
				dly_vld_q[i] <= dly_vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_rad_q[0] <= rr_sat;
			dly_mnz_q[0] <= rr_mnz;
			for (int i = 1; i < RAD_DLY; i++) begin
				dly_rad_q[i] <= dly_rad_q[i-1];
				dly_mnz_q[i] <= dly_mnz_q[i-1];
			end
		end
	end

	// xy root with normalized operands riding along
	logic                    rho_vld;
	logic [OPER_W-1:0]       rho;
	logic [SIDE_RHO-1:0]     rho_side;
	logic signed [INT_W-1:0] xs;
	logic signed [INT_W-1:0] ys;
	logic signed [INT_W-1:0] zs;
	logic                    xy_nz;

	c2s_sqrt #(
		.ROOT_W (OPER_W),
		.SIDE_W (SIDE_RHO)
	) u_rho_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s5),
		.rad_in   (rrad_s5),
		.side_in  ({sc_s5[0], sc_s5[1], sc_s5[2], xy_nz_s5}),
		.vld_out  (rho_vld),
		.root_out (rho),
		.side_out (rho_side)
	);

	assign {xs, ys, zs, xy_nz} = rho_side;

	logic                 p_vld;
	logic signed [AW-1:0] p_ang;
	logic [CW-1:0]        p_rad;
	logic                 p_mnz;
	logic                 a_vld;
	logic signed [AW-1:0] a_ang;
	logic                 a_xynz;

	c2s_cordic #(
		.STEPS  (ROTATION_STEPS),
		.AFB    (ANGLE_FRAC_BITS),
		.SIDE_W (CW + 1)
	) u_polar (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_in    (rho_vld && dly_vld_q[RAD_DLY-1]),
		.y_in      ($signed(INT_W'(rho))),
		.x_in      (zs),
		.side_in   ({dly_rad_q[RAD_DLY-1], dly_mnz_q[RAD_DLY-1]}),
		.vld_out   (p_vld),
		.angle_out (p_ang),
		.side_out  ({p_rad, p_mnz})
	);

	c2s_cordic #(
		.STEPS  (ROTATION_STEPS),
		.AFB    (ANGLE_FRAC_BITS),
		.SIDE_W (1)
	) u_azimuth (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_in    (rho_vld),
		.y_in      (ys),
		.x_in      (xs),
		.side_in   (xy_nz),
		.vld_out   (a_vld),
		.angle_out (a_ang),
		.side_out  (a_xynz)
	);

	logic [AW-2:0]        polar_c;
	logic signed [AW-1:0] az_c;

	always_comb begin
		priority if (!p_mnz || (p_ang < 0)) begin
			polar_c = '0;
		end else if (p_ang > PI_F) begin
			polar_c = PI_F[AW-2:0];
		end else begin
			polar_c = p_ang[AW-2:0];
		end
	end

	always_comb begin
		priority if (!a_xynz) begin
			az_c = '0;
		end else if (a_ang > PI_F) begin
			az_c = PI_F;
		end else if (a_ang < -PI_F) begin
			az_c = -PI_F;
		end else begin
			az_c = a_ang;
		end
	end

	logic [CW-1:0]        radius_q;
	logic [AW-2:0]        polar_q;
	logic signed [AW-1:0] az_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= p_vld && a_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			radius_q <= p_rad;
			polar_q  <= polar_c;
			az_q     <= az_c;
		end
	end

	assign res_valid     = res_valid_q;
	assign radius        = radius_q;
	assign polar_angle   = polar_q;
	assign azimuth_angle = az_q;

endmodule

`default_nettype wire

/* hdl/c2s_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit recurrence, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_sqrt #(
	parameter int ROOT_W = 33,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld_in,
	input  logic [2*ROOT_W-1:0] rad_in,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                vld_out,
	output logic [ROOT_W-1:0]   root_out,
	output logic [SIDE_W-1:0]   side_out
);
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0]  rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] q_s    [1:ROOT_W];
	logic [RAD_W-1:0]  rad_s  [1:ROOT_W];
	logic [SIDE_W-1:0] side_s [1:ROOT_W];
	logic              vld_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0]  rem_src;
		logic [ROOT_W-1:0] q_src;
		logic [RAD_W-1:0]  rad_src;
		logic [SIDE_W-1:0] side_src;
		logic              vld_src;
		logic [REM_W-1:0]  part;
		logic [REM_W-1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_src  = '0;
			assign q_src    = '0;
			assign rad_src  = rad_in;
			assign side_src = side_in;
			assign vld_src  = vld_in;
		end else begin : g_next
			assign rem_src  = rem_s[k];
			assign q_src    = q_s[k];
			assign rad_src  = rad_s[k];
			assign side_src = side_s[k];
			assign vld_src  = vld_s[k];
		end

		assign part  = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
		assign trial = {q_src, 2'b01};
		assign take  = (part >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_src;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= take ? (part - trial) : part;
				q_s[k+1]    <= {q_src[ROOT_W-2:0], take};
				rad_s[k+1]  <= {rad_src[RAD_W-3:0], 2'b00};
				side_s[k+1] <= side_src;
			end
		end
	end

	assign vld_out  = vld_s[ROOT_W];
	assign root_out = q_s[ROOT_W];
	assign side_out = side_s[ROOT_W];

endmodule

`default_nettype wire

/* hdl/c2s_cordic.sv */
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC arctangent
// Quadrant fold, one micro-rotation per stage, then rounding to the output grid.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_cordic #(
	parameter int STEPS  = 32,
	parameter int AFB    = 29,
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             vld_in,
	input  logic signed [c2s_pkg::INT_W-1:0] y_in,
	input  logic signed [c2s_pkg::INT_W-1:0] x_in,
	input  logic [SIDE_W-1:0]                side_in,
	output logic                             vld_out,
	output logic signed [AFB+2:0]            angle_out,
	output logic [SIDE_W-1:0]                side_out
);
	import c2s_pkg::*;

	localparam int AW = AFB + 3;
	localparam int SH = INT_FRAC - AFB;
	localparam logic [INT_W-1:0] QUARTER = atan_entry(0);
	localparam logic [INT_W-1:0] HALF_PI = QUARTER << 1;
	localparam logic [INT_W-1:0] PI_INT  = QUARTER << 2;
	localparam logic [INT_W-1:0] RND     = INT_W'(1) << (SH - 1);

	logic signed [INT_W-1:0] x_s    [0:STEPS];
	logic signed [INT_W-1:0] y_s    [0:STEPS];
	logic signed [INT_W-1:0] a_s    [0:STEPS];
	logic                    fix_s  [0:STEPS];
	logic [SIDE_W-1:0]       side_s [0:STEPS];
	logic                    vld_s  [0:STEPS];

	logic signed [INT_W-1:0] x0;
	logic signed [INT_W-1:0] y0;
	logic signed [INT_W-1:0] a0;
	logic                    fix0;

	always_comb begin
		x0   = x_in;
		y0   = y_in;
		a0   = '0;
		fix0 = 1'b0;
		priority if (y_in == '0) begin
			fix0 = 1'b1;
			a0   = (x_in >= 0) ? '0 : $signed(PI_INT);
		end else if (x_in == '0) begin
			fix0 = 1'b1;
			a0   = (y_in > 0) ? $signed(HALF_PI) : -$signed(HALF_PI);
		end else if (x_in < 0) begin
			if (y_in > 0) begin
				x0 = y_in;
				y0 = -x_in;
				a0 = $signed(HALF_PI);
			end else begin
				x0 = -y_in;
				y0 = x_in;
				a0 = -$signed(HALF_PI);
			end
		end else begin
			x0 = x_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]    <= x0;
			y_s[0]    <= y0;
			a_s[0]    <= a0;
			fix_s[0]  <= fix0;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam logic [INT_W-1:0] TAB = atan_entry(i);
		logic signed [INT_W-1:0] dx;
		logic signed [INT_W-1:0] dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fix_s[i+1]  <= fix_s[i];
				side_s[i+1] <= side_s[i];
				if (fix_s[i]) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					a_s[i+1] <= a_s[i];
				end else if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					a_s[i+1] <= a_s[i] + $signed(TAB);
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					a_s[i+1] <= a_s[i] - $signed(TAB);
				end
			end
		end
	end

	logic [INT_W-1:0]  mag_s1;
	logic              neg_s1;
	logic [SIDE_W-1:0] side_s1;
	logic              vld_s1;
	logic signed [AW-1:0] angle_s2;
	logic [SIDE_W-1:0]    side_s2;
	logic                 vld_s2;

	logic [INT_W-1:0] rsum;
	logic [AW-1:0]    rmag;

	assign rsum = mag_s1 + RND;
	assign rmag = AW'(rsum >> SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_s[STEPS];
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1   <= (a_s[STEPS] < 0);
			mag_s1   <= (a_s[STEPS] < 0) ? INT_W'(-a_s[STEPS]) : INT_W'(a_s[STEPS]);
			side_s1  <= side_s[STEPS];
			angle_s2 <= neg_s1 ? -$signed(rmag) : $signed(rmag);
			side_s2  <= side_s1;
		end
	end

	assign vld_out   = vld_s2;
	assign angle_out = angle_s2;
	assign side_out  = side_s2;

endmodule

`default_nettype wire

/* hdl/c2s_checker.sv */
// ----------------------------------------------------------------------------
// Cartesian to spherical port checker
// Watches the ports of the converter for handshake and result range slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cartesian_to_spherical_assert.svh"

module c2s_checker #(
	parameter int COORD_WIDTH     = 32,
	parameter int ANGLE_FRAC_BITS = 29
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              pt_valid,
	input logic                              pt_stall,
	input logic signed [COORD_WIDTH-1:0]     coord_x,
	input logic signed [COORD_WIDTH-1:0]     coord_y,
	input logic signed [COORD_WIDTH-1:0]     coord_z,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic [COORD_WIDTH-1:0]            radius,
	input logic [ANGLE_FRAC_BITS+1:0]        polar_angle,
	input logic signed [ANGLE_FRAC_BITS+2:0] azimuth_angle
);
	import c2s_pkg::*;

	localparam int AW = ANGLE_FRAC_BITS + 3;
	localparam logic [63:0] PI_RND = pi_round(ANGLE_FRAC_BITS);
	localparam logic [AW-2:0] PI_U = PI_RND[AW-2:0];
	localparam logic signed [AW-1:0] PI_S = $signed(PI_RND[AW-1:0]);

	logic pt_seen;
	assign pt_seen = pt_valid && (coord_x == coord_x) && (coord_y == coord_y)
		&& (coord_z == coord_z);

	`C2S_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
		res_valid && $stable(radius) && $stable(polar_angle) && $stable(azimuth_angle),
		"stalled result transaction changed")

	`C2S_ASSERT_NOW(a_pt_stall, pt_seen || !pt_seen, pt_stall == (res_valid && res_stall),
		"input stall does not follow the stalled output register")

	`C2S_ASSERT_NOW(a_polar_range, res_valid, polar_angle <= PI_U,
		"polar angle above pi")

	`C2S_ASSERT_NOW(a_az_range, res_valid, (azimuth_angle <= PI_S) && (azimuth_angle >= -PI_S),
		"azimuth outside -pi..pi")

	`C2S_ASSERT_NOW(a_zero_radius, res_valid && (radius == '0),
		(polar_angle == '0) && (azimuth_angle == '0),
		"nonzero angle for a point at the origin")

endmodule

bind cartesian_to_spherical c2s_checker #(
	.COORD_WIDTH     (COORD_WIDTH),
	.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_c2s_checker (.*);

`default_nettype wire

/* tb/cartesian_to_spherical_tb.sv */
// ----------------------------------------------------------------------------
// Cartesian to spherical converter testbench
// Drives directed and random points through the valid/stall input, stalls the
// result side in random bursts and one long hold-off, and checks radius, polar
// angle and azimuth against a bit-exact CORDIC predictor kept in this file.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical_tb;

	localparam int CW     = 32;
	localparam int AFB    = 29;
	localparam int STEPS  = 32;
	localparam int QFRAC  = 60;
	localparam int LIMIT  = 200000;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	typedef struct {
		logic [CW-1:0]         rad;
		logic [AFB+1:0]        polar;
		logic signed [AFB+2:0] azim;
	} sph_t;

	logic                  clk;
	logic                  arst_n;
	logic                  pt_valid;
	logic                  pt_stall;
	logic signed [CW-1:0]  coord_x;
	logic signed [CW-1:0]  coord_y;
	logic signed [CW-1:0]  coord_z;
	logic                  res_valid;
	logic                  res_stall;
	logic [CW-1:0]         radius;
	logic [AFB+1:0]        polar_angle;
	logic signed [AFB+2:0] azimuth_angle;

	point_t     point_q[$];
	sph_t       sph_q[$];
	logic [63:0] atan_q60[STEPS];
	longint     pi_q60;
	longint     pi_rnd;
	int         errors;
	int         n_points;
	int         n_results;
	int         cycles;
	int         tx_idle;
	int         rx_idle;
	logic       in_took;

	cartesian_to_spherical u_top (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_stall(pt_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.res_valid(res_valid), .res_stall(res_stall),
		.radius(radius), .polar_angle(polar_angle), .azimuth_angle(azimuth_angle)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] taylor_atan(logic [63:0] p0, logic [63:0] dv, int sh);
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] k;
		p   = p0;
		acc = '0;
		k   = '0;
		while (p != 0) begin
			if (k[0]) acc = acc - p / (2 * k + 1);
			else acc = acc + p / (2 * k + 1);
			k++;
			if (sh >= 64) p = 0;
			else p = (p >> sh) / dv;
		end
		return acc;
	endfunction

	function automatic longint round_q60(longint a);
		logic [63:0] m;
		m = (a < 0) ? -a : a;
		m = (m + (64'd1 << (QFRAC - AFB - 1))) >> (QFRAC - AFB);
		return (a < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s) r = c;
		end
		return r;
	endfunction

	function automatic longint atan2_q60(longint yv, longint xv);
		longint acc;
		longint t;
		longint dx;
		longint dy;
		acc = 0;
		if (yv == 0) return (xv >= 0) ? 0 : pi_q60;
		if (xv == 0) return (yv > 0) ? pi_q60 / 2 : -(pi_q60 / 2);
		if (xv < 0) begin
			t = xv;
			if (yv > 0) begin
				xv = yv; yv = -t; acc = pi_q60 / 2;
			end else begin
				xv = -yv; yv = t; acc = -(pi_q60 / 2);
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv > 0) begin
				xv += dx; yv -= dy; acc += longint'(atan_q60[i]);
			end else begin
				xv -= dx; yv += dy; acc -= longint'(atan_q60[i]);
			end
		end
		return acc;
	endfunction

	function automatic sph_t to_spherical(point_t p);
		sph_t        r;
		logic [63:0] mx;
		logic [63:0] my;
		logic [63:0] mz;
		logic [63:0] mmax;
		logic [63:0] rho;
		logic [63:0] rt;
		logic [127:0] sxy;
		logic [127:0] sall;
		int          b;
		int          g;
		longint      pol;
		longint      az;
		longint      sx;
		longint      sy;
		longint      sz;
		mx   = p.x[CW-1] ? -{{32{p.x[CW-1]}}, p.x} : {32'd0, p.x};
		my   = p.y[CW-1] ? -{{32{p.y[CW-1]}}, p.y} : {32'd0, p.y};
		mz   = p.z[CW-1] ? -{{32{p.z[CW-1]}}, p.z} : {32'd0, p.z};
		sxy  = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
		sall = sxy + {64'd0, mz} * {64'd0, mz};
		rt   = floor_sqrt(sall);
		r.rad = (rt > 64'hFFFF_FFFF) ? '1 : rt[CW-1:0];
		pol  = 0;
		az   = 0;
		mmax = mx;
		if (my > mmax) mmax = my;
		if (mz > mmax) mmax = mz;
		b = 0;
		while (b < 64 && (mmax >> b) != 0) b++;
		if (mmax != 0) begin
			g   = 57 - b;
			rho = floor_sqrt(sxy << (2 * g));
			sx  = p.x[CW-1] ? -longint'(mx << g) : longint'(mx << g);
			sy  = p.y[CW-1] ? -longint'(my << g) : longint'(my << g);
			sz  = p.z[CW-1] ? -longint'(mz << g) : longint'(mz << g);
			pol = round_q60(atan2_q60(longint'(rho), sz));
			if (pol < 0) pol = 0;
			if (pol > pi_rnd) pol = pi_rnd;
			if (mx != 0 || my != 0) begin
				az = round_q60(atan2_q60(sy, sx));
				if (az > pi_rnd) az = pi_rnd;
				if (az < -pi_rnd) az = -pi_rnd;
			end
		end
		r.polar = pol[AFB+1:0];
		r.azim  = az[AFB+2:0];
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 255))) - 128;
			2: return 32'sh8000_0000;
			3: return 32'sh7FFF_FFFF;
			4: return 0;
			default: return $signed($urandom) >>> $urandom_range(0, 30);
		endcase
	endfunction

	task automatic add_point(int x, int y, int z);
		point_t p;
		p.x = x; p.y = y; p.z = z;
		point_q.push_back(p);
	endtask

	// sender
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
			coord_x  <= '0;
			coord_y  <= '0;
			coord_z  <= '0;
			tx_idle  <= 0;
		end else if (!pt_valid || in_took) begin
			if (tx_idle > 0) begin
				pt_valid <= 1'b0;
				tx_idle  <= tx_idle - 1;
			end else if (point_q.size() > 0) begin
				pt_valid <= 1'b1;
				coord_x  <= point_q[0].x;
				coord_y  <= point_q[0].y;
				coord_z  <= point_q[0].z;
				void'(point_q.pop_front());
				if (point_q.size() > 120 && $urandom_range(0, 7) == 0)
					tx_idle <= $urandom_range(1, 10);
			end else begin
				pt_valid <= 1'b0;
			end
		end
	end

	// receiver: random bursts, one long hold-off, none near the end
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_idle   <= 0;
		end else if (cycles == 400) begin
			res_stall <= 1'b1;
			rx_idle   <= 400;
		end else if (rx_idle > 0) begin
			res_stall <= 1'b1;
			rx_idle   <= rx_idle - 1;
		end else if (point_q.size() > 120 && $urandom_range(0, 7) == 0) begin
			res_stall <= 1'b1;
			rx_idle   <= $urandom_range(0, 9);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		sph_t   e;
		point_t p;
		if (!arst_n) begin
			in_took <= 1'b0;
			cycles  <= 0;
		end else begin
			cycles  <= cycles + 1;
			in_took <= pt_valid && !pt_stall;
			if (pt_valid && !pt_stall) begin
				p.x = coord_x; p.y = coord_y; p.z = coord_z;
				sph_q.push_back(to_spherical(p));
				n_points++;
			end
			if (res_valid && !res_stall) begin
				n_results++;
				if (sph_q.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					e = sph_q.pop_front();
					if (radius !== e.rad) begin
						$error("radius: expected %0d, got %0d", e.rad, radius);
						errors++;
					end
					if (polar_angle !== e.polar) begin
						$error("polar_angle: expected %0d, got %0d", e.polar, polar_angle);
						errors++;
					end
					if (azimuth_angle !== e.azim) begin
						$error("azimuth_angle: expected %0d, got %0d", e.azim,
							azimuth_angle);
						errors++;
					end
				end
			end
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] quarter;
		errors    = 0;
		n_points  = 0;
		n_results = 0;
		quarter   = taylor_atan(64'd1 << 59, 64'd4, 0)
			+ taylor_atan((64'd1 << 60) / 3, 64'd9, 0);
		atan_q60[0] = quarter;
		for (int i = 1; i < STEPS; i++)
			atan_q60[i] = taylor_atan(64'd1 << (QFRAC - i), 64'd1, 2 * i);
		pi_q60 = longint'(quarter << 2);
		pi_rnd = round_q60(pi_q60);

		add_point(0, 0, 0);
		add_point(0, 0, 65536);
		add_point(0, 0, -65536);
		add_point(65536, 0, 0);
		add_point(-65536, 0, 0);
		add_point(0, 65536, 0);
		add_point(0, -65536, 0);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 0, 0);
		add_point(0, 32'h8000_0000, 0);
		add_point(0, 0, 32'h8000_0000);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 1);
		add_point(1, 1, 1);
		add_point(-1, -1, -1);
		add_point(-1, 0, 1);
		add_point(-1, 1, 0);
		add_point(-1, -1, 0);
		add_point(65536, 65536, 0);
		add_point(-123456, 7890, -98765);
		add_point(32'h7FFF_FFFF, -1, 32'h8000_0000);
		for (int i = 0; i < 700; i++)
			add_point(rand_coord(), rand_coord(), rand_coord());

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (point_q.size() == 0 && !pt_valid && sph_q.size() == 0);
		repeat (150) @(posedge clk);
		$display("%0d points sent, %0d results checked, incl. axes, extremes and a long stall",
			n_points, n_results);
		if (errors == 0 && sph_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
